@@ hdl/label_map_region_adjacency_assert.svh @@
// Assertion macros shared by the region adjacency RTL.
`ifndef LABEL_MAP_REGION_ADJACENCY_ASSERT_SVH
`define LABEL_MAP_REGION_ADJACENCY_ASSERT_SVH
`ifndef ASSERT_OFF
`define LADJ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m");
`define LADJ_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("%m");
`else
`define LADJ_ASSERT(name, clk, rst_n, prop)
`define LADJ_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/ladj_pkg.sv @@
// Types, constants and helpers of the region adjacency block.
`default_nettype none
package ladj_pkg;
  localparam int LABEL_W        = 8;
  localparam int CFG_W          = 11;
  localparam int MAX_LABELS_DEF = 256;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int WIDTH_RESET    = 1024;
  localparam int MIN_WIDTH      = 2;
  localparam int NPAIR          = 4;
  localparam int PAIR_IDX_W     = 2;
  localparam int RQ_DEPTH       = 16;
  localparam int RQ_RESERVE     = 6;
  localparam int ROW_LOG_MAX    = 6;

  typedef logic [LABEL_W-1:0] label_t;

  typedef struct packed {
    label_t a;
    label_t b;
    label_t c;
    label_t d;
    logic   eof;
    logic   win;
  } window_t;

  typedef struct packed {
    logic   ok;
    label_t lo;
    label_t hi;
  } pair_t;

  typedef struct packed {
    logic   chk;
    logic   hit_new;
    logic   last;
    label_t lo;
    label_t hi;
  } result_t;

  function automatic pair_t make_pair(label_t x, label_t y, int max_labels);
    pair_t p;
    if (x < y) begin
      p.lo = x;
      p.hi = y;
    end else begin
      p.lo = y;
      p.hi = x;
    end
    p.ok = (x != y) && (int'(p.hi) < max_labels);
    return p;
  endfunction
endpackage
`default_nettype wire

@@ hdl/ladj_pix_if.sv @@
// Input channel: one label beat per pixel.
`default_nettype none
interface ladj_pix_if;
  logic                  valid;
  logic                  ready;
  ladj_pkg::label_t      label;
  logic                  end_of_frame;
  modport source (output valid, output label, output end_of_frame, input ready);
  modport sink (input valid, input label, input end_of_frame, output ready);
endinterface
`default_nettype wire

@@ hdl/ladj_pair_if.sv @@
// Output channel: one adjacent label pair per beat.
`default_nettype none
interface ladj_pair_if;
  logic             valid;
  logic             ready;
  ladj_pkg::label_t label_low;
  ladj_pkg::label_t label_high;
  logic             last;
  modport source (output valid, output label_low, output label_high, output last,
                  input ready);
  modport sink (input valid, input label_low, input label_high, input last,
                output ready);
endinterface
`default_nettype wire

@@ hdl/ladj_ram.sv @@
// Generic simple dual-port RAM, registered read, read-first.
`default_nettype none
module ladj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

@@ hdl/ladj_window.sv @@
// Raster front end: width register, column tracking, row line buffer, 2x2 window.
`default_nettype none
module ladj_window #(
  parameter int MAX_WIDTH = ladj_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ladj_pkg::CFG_W-1:0] cfg_wdata_i,
  ladj_pix_if.sink                        pix_i,
  input  wire logic                       hold_i,
  output logic                            win_valid_o,
  input  wire logic                       win_ready_i,
  output ladj_pkg::window_t               win_o
);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (CW + 1 > ladj_pkg::CFG_W) ? CW + 1 : ladj_pkg::CFG_W;

  logic [ladj_pkg::CFG_W-1:0] width_q;
  logic [CW-1:0]              col_q;
  logic                       past_q;
  logic                       s1_valid_q;
  ladj_pkg::label_t           s1_label_q;
  logic                       s1_eof_q;
  logic                       s1_win_q;
  ladj_pkg::label_t           up_left_q;
  ladj_pkg::label_t           left_q;

  logic [CMPW-1:0]  width_ext, eff_w, col_inc;
  logic             col_wrap, acc, take;
  ladj_pkg::label_t row_rdata;

  always_comb begin
    width_ext = CMPW'(width_q);
    if (width_ext < CMPW'(ladj_pkg::MIN_WIDTH)) begin
      eff_w = CMPW'(ladj_pkg::MIN_WIDTH);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      eff_w = CMPW'(MAX_WIDTH);
    end else begin
      eff_w = width_ext;
    end
    col_inc  = CMPW'(col_q) + CMPW'(1);
    col_wrap = (col_inc >= eff_w);
  end

  assign pix_i.ready = (!s1_valid_q || win_ready_i) && !hold_i;
  assign acc         = pix_i.valid && pix_i.ready;
  assign take        = s1_valid_q && win_ready_i;

  // previous row labels; read and overwritten at the same column
  ladj_ram #(
    .WIDTH (ladj_pkg::LABEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (col_q),
    .wdata_i (pix_i.label),
    .re_i    (acc),
    .raddr_i (col_q),
    .rdata_o (row_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= ladj_pkg::CFG_W'(ladj_pkg::WIDTH_RESET);
      col_q      <= '0;
      past_q     <= 1'b0;
      s1_valid_q <= 1'b0;
      up_left_q  <= '0;
      left_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (acc) begin
        if (pix_i.end_of_frame) begin
          col_q  <= '0;
          past_q <= 1'b0;
        end else if (col_wrap) begin
          col_q  <= '0;
          past_q <= 1'b1;
        end else begin
          col_q  <= col_inc[CW-1:0];
        end
        s1_valid_q <= 1'b1;
      end else if (take) begin
        s1_valid_q <= 1'b0;
      end
      if (take) begin
        up_left_q <= s1_eof_q ? '0 : row_rdata;
        left_q    <= s1_eof_q ? '0 : s1_label_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_label_q <= pix_i.label;
      s1_eof_q   <= pix_i.end_of_frame;
      s1_win_q   <= past_q && (col_q != '0);
    end
  end

  assign win_valid_o = s1_valid_q;
  assign win_o = '{a: up_left_q, b: row_rdata, c: left_q, d: s1_label_q,
                   eof: s1_eof_q, win: s1_win_q};
endmodule
`default_nettype wire

@@ hdl/ladj_pair_seq.sv @@
// Pair sequencer: test-and-set of the pair bitmap, one pair per cycle, and frame clear.
`default_nettype none
`include "label_map_region_adjacency_assert.svh"
module ladj_pair_seq #(
  parameter int MAX_LABELS = ladj_pkg::MAX_LABELS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               win_valid_i,
  output logic                    win_ready_o,
  input  wire ladj_pkg::window_t  win_i,
  input  wire logic               space_ok_i,
  output ladj_pkg::result_t       res_o,
  output logic                    clearing_o
);
  localparam int FULL_L = 1 << ladj_pkg::LABEL_W;
  localparam int L      = (MAX_LABELS < FULL_L) ? MAX_LABELS : FULL_L;
  localparam int LW     = $clog2(L);
  localparam int IW     = 2 * LW;
  localparam int RB     = (IW > ladj_pkg::ROW_LOG_MAX) ? ladj_pkg::ROW_LOG_MAX : IW - 1;
  localparam int ROW_W  = 1 << RB;
  localparam int RAW    = IW - RB;
  localparam int ROWS   = 1 << RAW;

  logic                         s2_valid_q;
  logic [ladj_pkg::NPAIR-1:0]   s2_vld_q;
  ladj_pkg::label_t             s2_lo_q [ladj_pkg::NPAIR];
  ladj_pkg::label_t             s2_hi_q [ladj_pkg::NPAIR];
  logic                         s2_eof_q;

  logic                         ck_valid_q;
  ladj_pkg::label_t             ck_lo_q;
  ladj_pkg::label_t             ck_hi_q;
  logic                         ck_last_q;

  logic                         fwd_v_q;
  logic [RAW-1:0]               fwd_row_q;
  logic [ROW_W-1:0]             fwd_word_q;

  logic                         clr_arm_q;
  logic                         clr_active_q;
  logic [RAW-1:0]               clr_row_q;

  logic [ladj_pkg::PAIR_IDX_W-1:0] pick_idx;
  logic [ladj_pkg::NPAIR-1:0]      vld_rest, vld_new;
  logic                            issue, release_s2, load, can_load;
  ladj_pkg::label_t                is_lo, is_hi;
  logic [IW-1:0]                   is_idx, ck_idx;
  logic [RAW-1:0]                  ck_row;
  logic [RB-1:0]                   ck_bit;
  logic [ROW_W-1:0]                bm_rdata, word, set_word;
  logic                            seen, hit_new;
  logic                            bm_we;
  logic [RAW-1:0]                  bm_waddr;
  logic [ROW_W-1:0]                bm_wdata;
  ladj_pkg::pair_t                 cand [ladj_pkg::NPAIR];

  // first pending pair
  always_comb begin
    pick_idx = '0;
    for (int i = ladj_pkg::NPAIR - 1; i >= 0; i--) begin
      if (s2_vld_q[i]) begin
        pick_idx = ladj_pkg::PAIR_IDX_W'(i);
      end
    end
  end

  always_comb begin
    vld_rest = s2_vld_q;
    vld_rest[pick_idx] = 1'b0;
  end

  assign issue      = s2_valid_q && (s2_vld_q != '0);
  assign release_s2 = s2_valid_q && (vld_rest == '0);
  assign can_load   = (!s2_valid_q || (release_s2 && !s2_eof_q)) && !clr_arm_q
                      && !clr_active_q && space_ok_i;
  assign win_ready_o = can_load;
  assign load        = can_load && win_valid_i;

  // window pairs in test order: A-B, A-D, A-C, B-C
  assign cand[0] = ladj_pkg::make_pair(win_i.a, win_i.b, MAX_LABELS);
  assign cand[1] = ladj_pkg::make_pair(win_i.a, win_i.d, MAX_LABELS);
  assign cand[2] = ladj_pkg::make_pair(win_i.a, win_i.c, MAX_LABELS);
  assign cand[3] = ladj_pkg::make_pair(win_i.b, win_i.c, MAX_LABELS);

  always_comb begin
    for (int i = 0; i < ladj_pkg::NPAIR; i++) begin
      vld_new[i] = cand[i].ok && win_i.win;
    end
  end

  assign is_lo  = s2_lo_q[pick_idx];
  assign is_hi  = s2_hi_q[pick_idx];
  assign is_idx = {is_lo[LW-1:0], is_hi[LW-1:0]};
  assign ck_idx = {ck_lo_q[LW-1:0], ck_hi_q[LW-1:0]};
  assign ck_row = ck_idx[IW-1:RB];
  assign ck_bit = ck_idx[RB-1:0];

  // write of the read cycle is not in the read data: take it from the bypass
  assign word     = (fwd_v_q && (fwd_row_q == ck_row)) ? fwd_word_q : bm_rdata;
  assign seen     = word[ck_bit];
  assign hit_new  = ck_valid_q && !seen;
  assign set_word = word | (ROW_W'(1) << ck_bit);

  assign bm_we    = clr_active_q || hit_new;
  assign bm_waddr = clr_active_q ? clr_row_q : ck_row;
  assign bm_wdata = clr_active_q ? '0 : set_word;

  ladj_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .re_i    (issue),
    .raddr_i (is_idx[IW-1:RB]),
    .rdata_o (bm_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q   <= 1'b0;
      s2_vld_q     <= '0;
      ck_valid_q   <= 1'b0;
      fwd_v_q      <= 1'b0;
      clr_arm_q    <= 1'b0;
      clr_active_q <= 1'b1;
      clr_row_q    <= '0;
    end else begin
      if (load) begin
        s2_valid_q <= 1'b1;
        s2_vld_q   <= vld_new;
      end else if (release_s2) begin
        s2_valid_q <= 1'b0;
        s2_vld_q   <= '0;
      end else if (issue) begin
        s2_vld_q   <= vld_rest;
      end
      ck_valid_q <= issue;
      fwd_v_q    <= bm_we;
      clr_arm_q  <= release_s2 && s2_eof_q;
      if (clr_arm_q) begin
        clr_active_q <= 1'b1;
      end else if (clr_active_q) begin
        if (clr_row_q == RAW'(ROWS - 1)) begin
          clr_active_q <= 1'b0;
          clr_row_q    <= '0;
        end else begin
          clr_row_q    <= clr_row_q + RAW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < ladj_pkg::NPAIR; i++) begin
        s2_lo_q[i] <= cand[i].lo;
        s2_hi_q[i] <= cand[i].hi;
      end
      s2_eof_q <= win_i.eof;
    end
    if (issue) begin
      ck_lo_q   <= is_lo;
      ck_hi_q   <= is_hi;
      ck_last_q <= (vld_rest == '0);
    end
    fwd_row_q  <= bm_waddr;
    fwd_word_q <= bm_wdata;
  end

  assign res_o = '{chk: ck_valid_q, hit_new: hit_new, last: ck_last_q,
                   lo: ck_lo_q, hi: ck_hi_q};
  assign clearing_o = clr_active_q;

  `LADJ_ASSERT(a_no_check_in_clear, clk_i, rst_ni, !(ck_valid_q && clr_active_q))
  `LADJ_ASSERT_IMPLIES(a_no_issue_in_clear, clk_i, rst_ni, issue, !clr_arm_q && !clr_active_q)
endmodule
`default_nettype wire

@@ hdl/ladj_result_q.sv @@
// Result queue: pairs are held until their pixel is finished, then released in order.
`default_nettype none
`include "label_map_region_adjacency_assert.svh"
module ladj_result_q (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ladj_pkg::result_t res_i,
  output logic                   space_ok_o,
  ladj_pair_if.source            pair_o
);
  localparam int PW = $clog2(ladj_pkg::RQ_DEPTH);

  ladj_pkg::label_t lo_q [ladj_pkg::RQ_DEPTH];
  ladj_pkg::label_t hi_q [ladj_pkg::RQ_DEPTH];
  logic [ladj_pkg::RQ_DEPTH-1:0] last_q;
  logic [PW:0] wr_q, rd_q, cm_q;
  logic        pix_res_q;

  logic [PW:0]   cnt, wr_prev;
  logic [PW-1:0] wr_idx, rd_idx;
  logic          push, pop, fin;

  assign push    = res_i.chk && res_i.hit_new;
  assign fin     = res_i.chk && res_i.last;
  assign cnt     = wr_q - rd_q;
  assign wr_prev = wr_q - (PW+1)'(1);
  assign wr_idx  = wr_q[PW-1:0];
  assign rd_idx  = rd_q[PW-1:0];
  assign space_ok_o = cnt <= (PW+1)'(ladj_pkg::RQ_DEPTH - ladj_pkg::RQ_RESERVE);

  assign pair_o.valid      = (rd_q != cm_q);
  assign pop               = pair_o.valid && pair_o.ready;
  assign pair_o.label_low  = lo_q[rd_idx];
  assign pair_o.label_high = hi_q[rd_idx];
  assign pair_o.last       = last_q[rd_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q      <= '0;
      rd_q      <= '0;
      cm_q      <= '0;
      pix_res_q <= 1'b0;
    end else begin
      if (push) begin
        wr_q <= wr_q + (PW+1)'(1);
      end
      if (pop) begin
        rd_q <= rd_q + (PW+1)'(1);
      end
      if (fin) begin
        cm_q      <= push ? wr_q + (PW+1)'(1) : wr_q;
        pix_res_q <= 1'b0;
      end else if (push) begin
        pix_res_q <= 1'b1;
      end
    end
  end

  // last flag: on the new entry, or patched onto the pixel's previous entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      lo_q[wr_idx]   <= res_i.lo;
      hi_q[wr_idx]   <= res_i.hi;
      last_q[wr_idx] <= res_i.last;
    end else if (fin && pix_res_q) begin
      last_q[wr_prev[PW-1:0]] <= 1'b1;
    end
  end

  `LADJ_ASSERT(a_commit_in_range, clk_i, rst_ni, (cm_q - rd_q) <= (wr_q - rd_q))
  `LADJ_ASSERT(a_no_overflow, clk_i, rst_ni, cnt <= (PW+1)'(ladj_pkg::RQ_DEPTH))
endmodule
`default_nettype wire

@@ hdl/label_map_region_adjacency.sv @@
// Path: a pixel's pairs go through the window register, the pair register and the bitmap
//   check register into the result queue; all pairs of a pixel turn valid there together.
// Pairs: a window yields up to 4 pairs of two different labels below MAX_LABELS, tested in
//   turn; the single bitmap read port does one test-and-set per cycle while pairs are pending.
// Reset: async, active low; the pair bitmap then gets a clearing pass of one row per cycle
//   (1024 rows at defaults), repeated after every end-of-frame pixel; no input beats meanwhile.
`default_nettype none
module label_map_region_adjacency #(
  parameter int MAX_LABELS = ladj_pkg::MAX_LABELS_DEF,
  parameter int MAX_WIDTH  = ladj_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ladj_pkg::CFG_W-1:0] cfg_wdata_i,
  ladj_pix_if.sink                        pix_i,
  ladj_pair_if.source                     pair_o
);
  // front end -> sequencer: 2x2 window beat
  logic              win_valid, win_ready;
  ladj_pkg::window_t win;
  // sequencer -> queue: outcome of one bitmap test
  ladj_pkg::result_t res;
  logic              space_ok;
  logic              clearing;

  // column counter, line buffer, width register
  ladj_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_i),
    .hold_i      (clearing),
    .win_valid_o (win_valid),
    .win_ready_i (win_ready),
    .win_o       (win)
  );

  // read-modify-write of the pair bitmap with write bypass
  ladj_pair_seq #(
    .MAX_LABELS (MAX_LABELS)
  ) u_pair_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_valid_i (win_valid),
    .win_ready_o (win_ready),
    .win_i       (win),
    .space_ok_i  (space_ok),
    .res_o       (res),
    .clearing_o  (clearing)
  );

  // output queue decouples result beats from pixel processing
  ladj_result_q u_result_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .space_ok_o (space_ok),
    .pair_o     (pair_o)
  );
endmodule
`default_nettype wire

@@ test/tb_label_map_region_adjacency.sv @@
// Testbench of the region adjacency block: label maps in, checked label pairs out.
`timescale 1ns / 100ps
module tb_label_map_region_adjacency;
  typedef ladj_pkg::label_t label_t;

  // one pixel beat waiting for the driver
  typedef struct packed {
    label_t label;
    logic   eof;
  } pix_beat_t;

  // one adjacent pair as the block should report it
  typedef struct packed {
    label_t lo;
    label_t hi;
    logic   last;
  } adj_pair_t;

  localparam int MAX_W       = ladj_pkg::MAX_WIDTH_DEF;
  localparam int MAX_L       = ladj_pkg::MAX_LABELS_DEF;
  localparam int RAND_BEATS  = 210;
  // settle wait: covers the pipeline latency plus up to four pair beats, with a margin
  localparam int SETTLE_WAIT = 24;
  // bitmap clearing pass after reset and after each end of frame
  localparam int CLEAR_WAIT  = MAX_W + 80;
  localparam int CYCLE_LIMIT = 1000000;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [ladj_pkg::CFG_W-1:0] cfg_wdata_i;

  ladj_pix_if  pix_bus ();
  ladj_pair_if pair_bus ();

  label_map_region_adjacency i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_bus),
    .pair_o      (pair_bus)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Adjacency predictor: mirrors the block's row buffer, 2x2 window and the
  // pair bitmap; every accepted pixel beat appends its new pairs to
  // expected_pairs in the order the block must emit them.
  // ---------------------------------------------------------------------------
  logic [ladj_pkg::CFG_W-1:0] adj_width;
  label_t                     adj_row [MAX_W];
  label_t                     adj_left;
  label_t                     adj_up_left;
  int                         adj_col;
  bit                         adj_past_row;
  bit [MAX_L*MAX_L-1:0]       adj_seen;   // indexed by {lo, hi}
  adj_pair_t                  expected_pairs [$];

  pix_beat_t pix_backlog [$];
  int        mismatches = 0;
  int        cycle_cnt = 0;
  bit        src_idle_on = 1'b1;
  bit        sink_idle_on = 1'b1;

  // the register takes any 11-bit value; the block works with 2 .. MAX_W
  function automatic int clamp_width(input logic [ladj_pkg::CFG_W-1:0] w);
    if (w < ladj_pkg::MIN_WIDTH) return ladj_pkg::MIN_WIDTH;
    if (w > MAX_W) return MAX_W;
    return int'(w);
  endfunction

  // test-and-set of one unordered pair; 1 when it is new
  function automatic bit mark_pair(input label_t x, input label_t y, output adj_pair_t p);
    label_t lo, hi;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    p = '0;
    if (x == y || int'(hi) >= MAX_L) return 1'b0;
    if (adj_seen[{lo, hi}]) return 1'b0;
    adj_seen[{lo, hi}] = 1'b1;
    p.lo = lo;
    p.hi = hi;
    return 1'b1;
  endfunction

  function automatic void clear_frame();
    adj_seen     = '0;
    adj_left     = '0;
    adj_up_left  = '0;
    adj_col      = 0;
    adj_past_row = 1'b0;
  endfunction

  function automatic void adj_window_step(input label_t d, input logic eof);
    adj_pair_t found [ladj_pkg::NPAIR];
    label_t    xs [ladj_pkg::NPAIR];
    label_t    ys [ladj_pkg::NPAIR];
    adj_pair_t p;
    label_t    b;
    int        n, c;
    n = 0;
    c = adj_col;
    if (c >= MAX_W) c = 0;
    b = adj_row[c];
    if (adj_past_row && c >= 1) begin
      // window A B / C D with D the current pixel: A-B, A-D, A-C, B-C
      xs = '{adj_up_left, adj_up_left, adj_up_left, b};
      ys = '{b, d, adj_left, adj_left};
      for (int k = 0; k < ladj_pkg::NPAIR; k++) begin
        if (mark_pair(xs[k], ys[k], p)) begin
          found[n] = p;
          n++;
        end
      end
      for (int k = 0; k < n; k++) begin
        p = found[k];
        p.last = (k == n - 1);
        expected_pairs = {expected_pairs, p};
      end
    end
    adj_up_left = b;
    adj_row[c]  = d;
    adj_left    = d;
    if (c + 1 >= clamp_width(adj_width)) begin
      adj_col      = 0;
      adj_past_row = 1'b1;
    end else begin
      adj_col = c + 1;
    end
    if (eof) clear_frame();
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none, some short, a few long.
  // ---------------------------------------------------------------------------
  function automatic int pick_idle(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] pair check: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_pair(input label_t lo, input label_t hi, input logic last);
    adj_pair_t want;
    if (expected_pairs.size() == 0) begin
      report_mismatch($sformatf("unexpected pair %0d-%0d last=%0b", lo, hi, last));
      return;
    end
    want = expected_pairs.pop_front();
    if (lo !== want.lo)
      report_mismatch($sformatf("label_low %0d, want %0d", lo, want.lo));
    if (hi !== want.hi)
      report_mismatch($sformatf("label_high %0d, want %0d", hi, want.hi));
    if (last !== want.last)
      report_mismatch($sformatf("last %0b, want %0b (pair %0d-%0d)",
                                last, want.last, want.lo, want.hi));
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver: pops the backlog, holds each beat until accepted, and
  // feeds the predictor on the accepting edge.
  // ---------------------------------------------------------------------------
  int        src_gap;
  pix_beat_t nxt_beat;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_bus.valid        <= 1'b0;
      pix_bus.label        <= '0;
      pix_bus.end_of_frame <= 1'b0;
      src_gap              <= 0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) adj_window_step(pix_bus.label, pix_bus.end_of_frame);
      if (!pix_bus.valid || pix_bus.ready) begin
        if (src_gap != 0) begin
          src_gap       <= src_gap - 1;
          pix_bus.valid <= 1'b0;
        end else if (pix_backlog.size() != 0) begin
          nxt_beat              = pix_backlog.pop_front();
          pix_bus.valid        <= 1'b1;
          pix_bus.label        <= nxt_beat.label;
          pix_bus.end_of_frame <= nxt_beat.eof;
          src_gap              <= src_idle_on ? pick_idle(40) : 0;
        end else begin
          pix_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pair monitor: checks every accepted beat, stalls ready at random.
  // ---------------------------------------------------------------------------
  int sink_stall;
  int stall_len;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_bus.ready <= 1'b0;
      sink_stall     <= 0;
    end else begin
      if (pair_bus.valid && pair_bus.ready)
        check_pair(pair_bus.label_low, pair_bus.label_high, pair_bus.last);
      if (sink_stall != 0) begin
        sink_stall     <= sink_stall - 1;
        pair_bus.ready <= 1'b0;
      end else begin
        stall_len = sink_idle_on ? pick_idle(20) : 0;
        if (stall_len != 0) begin
          sink_stall     <= stall_len - 1;
          pair_bus.ready <= 1'b0;
        end else begin
          pair_bus.ready <= 1'b1;
        end
      end
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[%0t] timeout, %0d pairs still expected", $time, expected_pairs.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. The label generator keeps its own raster position so
  // that most pixels copy their left or upper neighbor: regions form, pairs
  // repeat and the seen-bit suppression gets exercised.
  // ---------------------------------------------------------------------------
  label_t gen_row [MAX_W];
  label_t gen_left;
  int     gen_col;
  int     gen_eff;
  label_t palette [8];
  int     pal_n;

  task automatic push_pix(input int label, input bit eof);
    pix_beat_t bt;
    bt.label    = label_t'(label);
    bt.eof      = eof;
    pix_backlog = {pix_backlog, bt};
  endtask

  task automatic push_gen(input bit eof);
    int     r;
    label_t v;
    r = $urandom_range(0, 99);
    if (pal_n == 0) v = label_t'($urandom_range(0, 255));
    else if (r < 40 && gen_col != 0) v = gen_left;
    else if (r < 65) v = gen_row[gen_col];
    else v = palette[$urandom_range(0, pal_n - 1)];
    push_pix(v, eof);
    gen_row[gen_col] = v;
    gen_left         = v;
    gen_col          = (gen_col + 1 >= gen_eff || eof) ? 0 : gen_col + 1;
  endtask

  // new palette and new idling mode per frame; some frames are pure noise
  task automatic start_frame();
    pal_n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(2, 6);
    for (int i = 0; i < 8; i++) palette[i] = label_t'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      palette[0] = '0;
      palette[1] = '1;
    end
    src_idle_on  = ($urandom_range(0, 3) != 0);
    sink_idle_on = ($urandom_range(0, 3) != 0);
  endtask

  // wait until every beat is in and every pair is out, then let the block settle
  task automatic drain(input bit clearing);
    do @(negedge clk_i);
    while (pix_backlog.size() != 0 || pix_bus.valid || expected_pairs.size() != 0);
    repeat (clearing ? CLEAR_WAIT : SETTLE_WAIT) @(negedge clk_i);
  endtask

  // only called while idle, so the predictor can take the value at once
  task automatic write_width(input int w);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w[ladj_pkg::CFG_W-1:0];
    adj_width    = w[ladj_pkg::CFG_W-1:0];
    gen_eff      = clamp_width(adj_width);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int r, w, n, cut, rand_beats;
    pix_bus.valid        = 1'b0;
    pix_bus.label        = '0;
    pix_bus.end_of_frame = 1'b0;
    pair_bus.ready       = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    rst_ni               = 1'b0;
    adj_width            = ladj_pkg::WIDTH_RESET;
    for (int i = 0; i < MAX_W; i++) adj_row[i] = '0;
    clear_frame();
    gen_eff  = clamp_width(adj_width);
    gen_col  = 0;
    gen_left = '0;
    for (int i = 0; i < MAX_W; i++) gen_row[i] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain(1'b1);   // bitmap clearing pass after reset

    // --- directed part ---
    // width 0 clamps to 2; labels at both extremes, pairs found then repeated
    write_width(0);
    push_pix(0, 0);   push_pix(255, 0);
    push_pix(255, 0); push_pix(0, 0);
    push_pix(7, 0);   push_pix(7, 0);
    push_pix(7, 0);   push_pix(9, 1);
    drain(1'b1);
    // width 1 clamps to 2; the same pair comes again since end of frame cleared it
    write_width(1);
    push_pix(0, 0);   push_pix(255, 0);
    push_pix(255, 0); push_pix(0, 1);
    drain(1'b1);
    // four different labels in each window: four pairs per pixel
    write_width(3);
    push_pix(1, 0); push_pix(2, 0); push_pix(5, 0);
    push_pix(3, 0); push_pix(4, 0); push_pix(6, 1);
    drain(1'b1);
    // width shrinks mid-row: the column is past the new width and wraps
    write_width(5);
    for (int i = 0; i < 5; i++) push_pix(10 + i, 0);
    push_pix(20, 0); push_pix(21, 0); push_pix(22, 0);
    drain(1'b0);
    write_width(2);
    push_pix(23, 0); push_pix(24, 0); push_pix(25, 0); push_pix(26, 1);
    drain(1'b1);

    // a short frame at the top of the range: 2047 clamps to the widest row
    write_width(2047);
    start_frame();
    for (int i = 0; i < 12; i++) push_gen(i == 11);
    drain(1'b1);

    // --- random frames ---
    rand_beats = 0;
    while (rand_beats < RAND_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 65) w = $urandom_range(2, 8);
      else if (r < 80) w = $urandom_range(9, 20);
      else if (r < 88) w = $urandom_range(0, 1);
      else if (r < 95) w = $urandom_range(MAX_W + 1, 2047);
      else w = MAX_W;
      write_width(w);
      start_frame();
      // wide rows get short frames; some frames end inside their first row
      if (gen_eff > 20) n = $urandom_range(1, 12);
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(1, gen_eff);
      else n = gen_eff * $urandom_range(2, (gen_eff > 8) ? 3 : 6) + $urandom_range(0, gen_eff - 1);
      // now and then the row shrinks mid-frame (never grows: the row buffer
      // would be read where it was not written)
      cut = (gen_eff > 2 && n > 2 && $urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
        if (i == cut) begin
          drain(1'b0);
          write_width($urandom_range(0, gen_eff - 1));
        end
        push_gen(i == n - 1);
      end
      drain(1'b1);
      rand_beats += n;
    end

    drain(1'b0);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
